>>> rtl/sip_pkg.sv
`default_nettype none

package sip_pkg;

    // Default width of the end offset and position counter
    localparam int OffsetBitsDefault = 16;

    // Character codes used by the parser
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharLowA  = 8'h61;
    localparam logic [7:0] CharLowZ  = 8'h7a;
    localparam logic [7:0] CharUpA   = 8'h41;
    localparam logic [7:0] CharUpZ   = 8'h5a;
    localparam logic [7:0] CharLowX  = 8'h78;
    localparam logic [7:0] CharUpX   = 8'h58;
    localparam logic [7:0] CharMinus = 8'h2d;
    localparam logic [7:0] CharPlus  = 8'h2b;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharTab   = 8'h09;
    localparam logic [7:0] CharLf    = 8'h0a;
    localparam logic [7:0] CharVt    = 8'h0b;
    localparam logic [7:0] CharFf    = 8'h0c;
    localparam logic [7:0] CharCr    = 8'h0d;

    // Bases with special handling
    localparam logic [5:0] BaseAuto  = 6'd0;
    localparam logic [5:0] BaseOctal = 6'd8;
    localparam logic [5:0] BaseDec   = 6'd10;
    localparam logic [5:0] BaseHex   = 6'd16;

    // Digit code for a character that is not a digit in the base
    localparam logic [5:0] NoDigit = 6'd63;

    // One input item as held in the input register
    typedef struct packed {
        logic [7:0] char_in;
        logic       first_char;
        logic [5:0] radix;
        logic       signed_mode;
    } sip_item_t;

    // Fixed-width part of one result item
    typedef struct packed {
        logic [63:0] value;
        logic        found_digits;
        logic        overflow;
    } sip_result_t;

    // Whitespace skipped before the number
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CharSpace) || (c == CharTab) || (c == CharLf) ||
               (c == CharCr) || (c == CharVt) || (c == CharFf);
    endfunction

    // Digit value of a character, or NoDigit if it is not below the base
    function automatic logic [5:0] digit_of(input logic [7:0] c, input logic [5:0] base);
        logic [7:0] v;
        v = {2'b00, NoDigit};
        if (c >= CharZero && c <= CharNine)
        begin
            v = c - CharZero;
        end
        else if (c >= CharLowA && c <= CharLowZ)
        begin
            v = c - CharLowA + 8'd10;
        end
        else if (c >= CharUpA && c <= CharUpZ)
        begin
            v = c - CharUpA + 8'd10;
        end
        if (v < {2'b00, base})
        begin
            return v[5:0];
        end
        return NoDigit;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sip_mac.sv
`default_nettype none

module sip_mac (
    input  wire logic [63:0] acc,
    input  wire logic [5:0]  base,
    input  wire logic [5:0]  digit,
    output logic      [63:0] sum,
    output logic             carry
);

    logic [69:0] full;

    // Multiply-add at full width; any bit from 64 up marks a wrap
    assign full  = ({6'd0, acc} * {64'd0, base}) + {64'd0, digit};
    assign sum   = full[63:0];
    assign carry = |full[69:64];

endmodule

`default_nettype wire

>>> rtl/sip_core.sv
`default_nettype none

module sip_core #(
    parameter int OFFSET_BITS = sip_pkg::OffsetBitsDefault
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   fire,
    input  wire sip_pkg::sip_item_t     item,
    output logic                        emit,
    output sip_pkg::sip_result_t        result,
    output logic [OFFSET_BITS-1:0]      end_offset
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEAD   = 3'd1;
    localparam logic [2:0] PH_SIGNED = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_XSEEN  = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;

    localparam logic [OFFSET_BITS-1:0] PosMax = {OFFSET_BITS{1'b1}};

    logic [2:0]             phase_reg, phase_next;
    logic                   negative_reg, negative_next;
    logic [5:0]             base_reg, base_next;
    logic                   signed_reg;
    logic [63:0]            acc_reg, acc_next;
    logic                   any_reg, any_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic                   wrapped_reg, wrapped_next;

    logic [2:0]             eff_phase;
    logic                   eff_negative;
    logic [5:0]             eff_base;
    logic                   eff_signed;
    logic [63:0]            eff_acc;
    logic                   eff_any;
    logic [OFFSET_BITS-1:0] eff_pos;
    logic                   eff_wrapped;

    logic                   active;
    logic                   stop;
    logic [OFFSET_BITS-1:0] stop_pos;
    logic [5:0]             base_sel;
    logic [5:0]             digit;
    logic                   digit_ok;
    logic [63:0]            mac_sum;
    logic                   mac_carry;
    logic [7:0]             c;

    assign c = item.char_in;

    // A first character opens a fresh string; otherwise idle drops the item
    assign active = fire && (item.first_char || (phase_reg != PH_IDLE));

    always_comb
    begin
        if (item.first_char)
        begin
            eff_phase    = PH_LEAD;
            eff_negative = 1'b0;
            eff_base     = item.radix;
            eff_signed   = item.signed_mode;
            eff_acc      = '0;
            eff_any      = 1'b0;
            eff_pos      = '0;
            eff_wrapped  = 1'b0;
        end
        else
        begin
            eff_phase    = phase_reg;
            eff_negative = negative_reg;
            eff_base     = base_reg;
            eff_signed   = signed_reg;
            eff_acc      = acc_reg;
            eff_any      = any_reg;
            eff_pos      = pos_reg;
            eff_wrapped  = wrapped_reg;
        end
    end

    // Pick the base that the current phase classifies digits in
    always_comb
    begin
        base_sel = eff_base;
        case (eff_phase) inside
            PH_LEAD, PH_SIGNED:
            begin
                if (eff_base == sip_pkg::BaseAuto)
                begin
                    base_sel = sip_pkg::BaseDec;
                end
            end
            PH_ZERO:
            begin
                if (eff_base == sip_pkg::BaseAuto)
                begin
                    base_sel = sip_pkg::BaseOctal;
                end
            end
            PH_XSEEN:
            begin
                base_sel = sip_pkg::BaseHex;
            end
            default:
            begin
                base_sel = eff_base;
            end
        endcase
    end

    assign digit    = sip_pkg::digit_of(c, base_sel);
    assign digit_ok = (digit != sip_pkg::NoDigit);

    sip_mac u_mac (
        .acc   (eff_acc),
        .base  (base_sel),
        .digit (digit),
        .sum   (mac_sum),
        .carry (mac_carry)
    );

    // Step the parser by one character
    always_comb
    begin
        phase_next    = eff_phase;
        negative_next = eff_negative;
        base_next     = eff_base;
        acc_next      = eff_acc;
        any_next      = eff_any;
        wrapped_next  = eff_wrapped;
        stop          = 1'b0;
        stop_pos      = eff_pos;
        unique case (eff_phase) inside
            PH_LEAD, PH_SIGNED:
            begin
                if ((eff_phase == PH_LEAD) && sip_pkg::is_blank(c))
                begin
                    phase_next = PH_LEAD;
                end
                else if ((eff_phase == PH_LEAD) && (c == sip_pkg::CharMinus) && eff_signed)
                begin
                    negative_next = 1'b1;
                    phase_next    = PH_SIGNED;
                end
                else if ((eff_phase == PH_LEAD) && (c == sip_pkg::CharPlus))
                begin
                    phase_next = PH_SIGNED;
                end
                else if ((c == sip_pkg::CharZero) &&
                         ((eff_base == sip_pkg::BaseAuto) || (eff_base == sip_pkg::BaseHex)))
                begin
                    any_next   = 1'b1;
                    acc_next   = '0;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    base_next = base_sel;
                    if (!digit_ok)
                    begin
                        stop = 1'b1;
                    end
                    else
                    begin
                        acc_next     = mac_sum;
                        any_next     = 1'b1;
                        wrapped_next = eff_wrapped | mac_carry;
                        phase_next   = PH_DIGITS;
                    end
                end
            end
            PH_ZERO:
            begin
                if ((c == sip_pkg::CharLowX) || (c == sip_pkg::CharUpX))
                begin
                    phase_next = PH_XSEEN;
                end
                else
                begin
                    base_next = base_sel;
                    if (!digit_ok)
                    begin
                        stop = 1'b1;
                    end
                    else
                    begin
                        acc_next     = mac_sum;
                        any_next     = 1'b1;
                        wrapped_next = eff_wrapped | mac_carry;
                        phase_next   = PH_DIGITS;
                    end
                end
            end
            PH_XSEEN:
            begin
                base_next = base_sel;
                if (!digit_ok)
                begin
                    // End falls back to just after the zero when the x starts no number
                    stop     = 1'b1;
                    stop_pos = (eff_pos == PosMax) ? eff_pos : eff_pos - 1'b1;
                end
                else
                begin
                    acc_next     = mac_sum;
                    any_next     = 1'b1;
                    wrapped_next = eff_wrapped | mac_carry;
                    phase_next   = PH_DIGITS;
                end
            end
            PH_DIGITS:
            begin
                if (!digit_ok)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    acc_next     = mac_sum;
                    any_next     = 1'b1;
                    wrapped_next = eff_wrapped | mac_carry;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        if (stop)
        begin
            phase_next = PH_IDLE;
        end
        pos_next = (!stop && (eff_pos != PosMax)) ? eff_pos + 1'b1 : eff_pos;
    end

    // Form the result from the state before this character
    assign emit                = active && stop;
    assign result.value        = !eff_any ? 64'd0 :
                                 (eff_signed && eff_negative) ? (64'd0 - eff_acc) : eff_acc;
    assign result.found_digits = eff_any;
    assign result.overflow     = eff_wrapped;
    assign end_offset          = eff_any ? stop_pos : '0;

    // Hold the parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            negative_reg <= 1'b0;
            base_reg     <= '0;
            signed_reg   <= 1'b0;
            acc_reg      <= '0;
            any_reg      <= 1'b0;
            pos_reg      <= '0;
            wrapped_reg  <= 1'b0;
        end
        else if (active)
        begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            base_reg     <= base_next;
            signed_reg   <= eff_signed;
            acc_reg      <= acc_next;
            any_reg      <= any_next;
            pos_reg      <= pos_next;
            wrapped_reg  <= wrapped_next;
        end
    end

    a_stop_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (phase_reg == PH_IDLE))
        else $error("parser did not go idle after a result");

    a_idle_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !item.first_char && (phase_reg == PH_IDLE)) |=> $stable(pos_reg))
        else $error("idle item moved the position");

    a_no_digit_zero_acc: assert property (@(posedge clk) disable iff (!rst_n)
        !any_reg |-> (acc_reg == 64'd0))
        else $error("accumulator set without a digit");

endmodule

`default_nettype wire

>>> rtl/string_to_integer_parser.sv
`default_nettype none

// Channel  Handshake            Payload
// -------  -------------------  ------------------------------------------
// in       in_valid / in_stall  char_in, first_char, radix, signed_mode
// out      out_valid/ out_stall value, end_offset, found_digits, overflow
//
// One character is taken every cycle while in_stall is low; the result
// of a stop character passes the input register, then the result
// register, with the single multiply-add step between them.
// rst_n clears the valid flags and the parser state at once.
// A stalled result holds the step; the input register then raises in_stall.

module string_to_integer_parser #(
    parameter int OFFSET_BITS = sip_pkg::OffsetBitsDefault
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             char_in,
    input  wire logic                   first_char,
    input  wire logic [5:0]             radix,
    input  wire logic                   signed_mode,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [63:0]                 value,
    output logic [OFFSET_BITS-1:0]      end_offset,
    output logic                        found_digits,
    output logic                        overflow
);

    logic                    in_valid_reg;
    sip_pkg::sip_item_t      item_reg;
    logic                    out_valid_reg;
    sip_pkg::sip_result_t    result_reg;
    logic [OFFSET_BITS-1:0]  offset_reg;

    logic                    step_go;
    logic                    core_emit;
    sip_pkg::sip_result_t    core_result;
    logic [OFFSET_BITS-1:0]  core_offset;

    // Advance the step when the result register is free or being taken
    assign step_go  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !step_go;

    // Capture the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            item_reg.char_in     <= char_in;
            item_reg.first_char  <= first_char;
            item_reg.radix       <= radix;
            item_reg.signed_mode <= signed_mode;
        end
    end

    sip_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_valid_reg && step_go),
        .item       (item_reg),
        .emit       (core_emit),
        .result     (core_result),
        .end_offset (core_offset)
    );

    // Load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_go)
        begin
            out_valid_reg <= core_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go && core_emit)
        begin
            result_reg <= core_result;
            offset_reg <= core_offset;
        end
    end

    assign out_valid    = out_valid_reg;
    assign value        = result_reg.value;
    assign found_digits = result_reg.found_digits;
    assign overflow     = result_reg.overflow;
    assign end_offset   = offset_reg;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_valid_reg)
        else $error("accepted item lost from the input register");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> $past(in_valid_reg))
        else $error("result appeared without an item in the step");

endmodule

`default_nettype wire

>>> test/tb_string_to_integer_parser.sv
module tb_string_to_integer_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import sip_pkg::*;

    localparam int OffsetW = OffsetBitsDefault;
    localparam logic [OffsetW-1:0] PosMax = '1;
    localparam int RandomItems = 1650;
    localparam int IdleLimit = 2000;
    localparam int DrainCycles = 10;
    localparam int PrintCap = 100;

    // Bases used by the stimulus beyond those in the package
    localparam logic [5:0] BaseUnary = 6'd1;
    localparam logic [5:0] BaseBin   = 6'd2;
    localparam logic [5:0] BaseMax   = 6'd36;
    localparam logic [5:0] BaseTop   = 6'd63;
    localparam logic [7:0] CharNul   = 8'h00;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_LEAD,
        SCAN_SIGN,
        SCAN_ZERO,
        SCAN_XSEEN,
        SCAN_DIGITS
    } scan_phase_e;

    typedef struct {
        logic [63:0]        value;
        logic [OffsetW-1:0] end_offset;
        logic               found;
        logic               wrap;
    } parse_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         char_in = 8'h00;
    logic               first_char = 1'b0;
    logic [5:0]         radix = 6'd0;
    logic               signed_mode = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [63:0]        value;
    logic [OffsetW-1:0] end_offset;
    logic               found_digits;
    logic               overflow;

    string_to_integer_parser #(
        .OFFSET_BITS(OffsetW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .char_in(char_in),
        .first_char(first_char),
        .radix(radix),
        .signed_mode(signed_mode),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .value(value),
        .end_offset(end_offset),
        .found_digits(found_digits),
        .overflow(overflow)
    );

    sip_item_t     pending_items[$];
    parse_result_t awaited_parses[$];
    int            total_items = 0;
    int            accepted_count = 0;
    int            error_count = 0;
    int            idle_cycles = 0;
    int            random_count = 0;

    // Parser state as predicted
    scan_phase_e        scan_phase = SCAN_IDLE;
    logic               is_negative = 1'b0;
    logic [5:0]         cur_base = 6'd0;
    logic               keep_sign = 1'b0;
    logic [63:0]        acc = 64'd0;
    logic               saw_digit = 1'b0;
    logic [OffsetW-1:0] char_pos = '0;
    logic               did_wrap = 1'b0;
    logic               string_closed = 1'b0;

    // Stimulus builder state
    logic [5:0] gen_radix = 6'd0;
    logic       gen_signed = 1'b0;
    logic       gen_opening = 1'b0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic is_blank_char(input logic [7:0] c);
        case (c)
            CharSpace, CharTab, CharLf, CharCr, CharVt, CharFf: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [5:0] char_digit(input logic [7:0] c, input logic [5:0] base);
        int v;
        v = 64;
        if (c >= CharZero && c <= CharNine)
        begin
            v = int'(c) - int'(CharZero);
        end
        else if (c >= CharLowA && c <= CharLowZ)
        begin
            v = int'(c) - int'(CharLowA) + 10;
        end
        else if (c >= CharUpA && c <= CharUpZ)
        begin
            v = int'(c) - int'(CharUpA) + 10;
        end
        return (v < int'(base)) ? 6'(v) : NoDigit;
    endfunction

    // Close the string and queue the parse it yields
    task automatic finish_string(input logic [OffsetW-1:0] stop_at);
        parse_result_t r;
        logic [63:0] v;
        v = (keep_sign && is_negative) ? 64'd0 - acc : acc;
        r.value = saw_digit ? v : 64'd0;
        r.end_offset = saw_digit ? stop_at : '0;
        r.found = saw_digit;
        r.wrap = did_wrap;
        awaited_parses.push_back(r);
        scan_phase = SCAN_IDLE;
        string_closed = 1'b1;
    endtask

    // Multiply-add one digit, flag a carry out of 64 bits
    task automatic add_digit(input logic [5:0] d);
        logic [70:0] wide;
        wide = {7'd0, acc} * {65'd0, cur_base} + {65'd0, d};
        if (wide[70:64] != 7'd0)
        begin
            did_wrap = 1'b1;
        end
        acc = wide[63:0];
        saw_digit = 1'b1;
    endtask

    task automatic begin_number(input logic [7:0] c);
        logic [5:0] d;
        if (c == CharZero && (cur_base == BaseAuto || cur_base == BaseHex))
        begin
            saw_digit = 1'b1;
            acc = 64'd0;
            scan_phase = SCAN_ZERO;
        end
        else
        begin
            if (cur_base == BaseAuto)
            begin
                cur_base = BaseDec;
            end
            d = char_digit(c, cur_base);
            if (d == NoDigit)
            begin
                finish_string(char_pos);
            end
            else
            begin
                add_digit(d);
                scan_phase = SCAN_DIGITS;
            end
        end
    endtask

    // Advance the predicted parser by one accepted character
    task automatic scan_char(input logic [7:0] c, input logic opening,
                             input logic [5:0] rdx, input logic sgn);
        logic [5:0] d;
        string_closed = 1'b0;
        if (opening)
        begin
            is_negative = 1'b0;
            acc = 64'd0;
            saw_digit = 1'b0;
            char_pos = '0;
            did_wrap = 1'b0;
            scan_phase = SCAN_LEAD;
            cur_base = rdx;
            keep_sign = sgn;
        end
        if (scan_phase != SCAN_IDLE)
        begin
            case (scan_phase)
                SCAN_LEAD:
                begin
                    if (!is_blank_char(c))
                    begin
                        if (c == CharMinus && keep_sign)
                        begin
                            is_negative = 1'b1;
                            scan_phase = SCAN_SIGN;
                        end
                        else if (c == CharPlus)
                        begin
                            scan_phase = SCAN_SIGN;
                        end
                        else
                        begin
                            begin_number(c);
                        end
                    end
                end
                SCAN_SIGN:
                begin
                    begin_number(c);
                end
                SCAN_ZERO:
                begin
                    if (c == CharLowX || c == CharUpX)
                    begin
                        scan_phase = SCAN_XSEEN;
                    end
                    else
                    begin
                        if (cur_base == BaseAuto)
                        begin
                            cur_base = BaseOctal;
                        end
                        d = char_digit(c, cur_base);
                        if (d == NoDigit)
                        begin
                            finish_string(char_pos);
                        end
                        else
                        begin
                            add_digit(d);
                            scan_phase = SCAN_DIGITS;
                        end
                    end
                end
                SCAN_XSEEN:
                begin
                    // A bare 0x ends just after the zero
                    cur_base = BaseHex;
                    d = char_digit(c, BaseHex);
                    if (d == NoDigit)
                    begin
                        finish_string(char_pos == PosMax ? char_pos : char_pos - 1'b1);
                    end
                    else
                    begin
                        add_digit(d);
                        scan_phase = SCAN_DIGITS;
                    end
                end
                default:
                begin
                    d = char_digit(c, cur_base);
                    if (d == NoDigit)
                    begin
                        finish_string(char_pos);
                    end
                    else
                    begin
                        add_digit(d);
                    end
                end
            endcase
            if (!string_closed && char_pos != PosMax)
            begin
                char_pos = char_pos + 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < PrintCap)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic int pick_wait(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10)
        begin
            return CharZero + 8'(d);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            return CharLowA + 8'(d - 10);
        end
        return CharUpA + 8'(d - 10);
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 5))
            0: return CharSpace;
            1: return CharTab;
            2: return CharLf;
            3: return CharVt;
            4: return CharFf;
            default: return CharCr;
        endcase
    endfunction

    // Queue one character; fields other than the character are don't-care
    // after the opening one, so randomize them there
    task automatic put_char(input logic [7:0] c);
        sip_item_t it;
        it.char_in = c;
        it.first_char = gen_opening;
        it.radix = gen_opening ? gen_radix : 6'($urandom_range(0, 63));
        it.signed_mode = gen_opening ? gen_signed : 1'($urandom_range(0, 1));
        pending_items.push_back(it);
        gen_opening = 1'b0;
        random_count++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            put_char(s[i]);
        end
    endtask

    task automatic begin_string(input logic [5:0] rdx, input logic sgn);
        gen_radix = rdx;
        gen_signed = sgn;
        gen_opening = 1'b1;
    endtask

    // Build one random string: mostly well formed, some noise
    task automatic gen_random_string();
        int r;
        int eff;
        int n;
        bit maxed;
        logic [5:0] rdx;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            case ($urandom_range(0, 5))
                0: rdx = BaseAuto;
                1: rdx = BaseBin;
                2: rdx = BaseOctal;
                3: rdx = BaseDec;
                4: rdx = BaseHex;
                default: rdx = BaseMax;
            endcase
        end
        else if (r < 90)
        begin
            rdx = 6'($urandom_range(2, 36));
        end
        else
        begin
            rdx = 6'($urandom_range(0, 63));
        end
        begin_string(rdx, 1'($urandom_range(0, 1)));

        if ($urandom_range(0, 9) < 7)
        begin
            repeat ($urandom_range(0, 2)) put_char(random_blank());
            case ($urandom_range(0, 3))
                0: put_char(CharMinus);
                1: put_char(CharPlus);
                default: ;
            endcase
            eff = int'(rdx);
            if (rdx == BaseAuto)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        put_char(CharZero);
                        put_char($urandom_range(0, 1) ? CharLowX : CharUpX);
                        eff = 16;
                    end
                    1:
                    begin
                        put_char(CharZero);
                        eff = 8;
                    end
                    default: eff = 10;
                endcase
            end
            else if (rdx == BaseHex && $urandom_range(0, 2) == 0)
            begin
                put_char(CharZero);
                put_char($urandom_range(0, 1) ? CharLowX : CharUpX);
            end
            if (eff > 36)
            begin
                eff = 36;
            end
            maxed = ($urandom_range(0, 7) == 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
            repeat (n) put_char(digit_char(maxed ? eff - 1 : $urandom_range(0, eff - 1)));
            r = $urandom_range(0, 9);
            if (r < 5)
            begin
                put_char(CharNul);
            end
            else if (r < 9)
            begin
                put_char(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 5))
            begin
                case ($urandom_range(0, 7))
                    0: put_char(CharMinus);
                    1: put_char(CharPlus);
                    2: put_char(CharZero);
                    3: put_char(CharLowX);
                    4: put_char(random_blank());
                    default: put_char(8'($urandom_range(0, 255)));
                endcase
            end
        end
        // Trailing character: ignored once the string has ended
        if ($urandom_range(0, 4) == 0)
        begin
            put_char(8'($urandom_range(0, 255)));
        end
    endtask

    // Drive input items from the queue with random gaps
    int  gap_left = 0;
    bit  in_quiet = 1'b0;
    bit  took;
    sip_item_t next_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            took = (in_valid === 1'b1) && (in_stall === 1'b0);
            if (took)
            begin
                scan_char(char_in, first_char, radix, signed_mode);
                accepted_count++;
            end
            if (!in_valid || took)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    char_in <= next_item.char_in;
                    first_char <= next_item.first_char;
                    radix <= next_item.radix;
                    signed_mode <= next_item.signed_mode;
                    in_valid <= 1'b1;
                    gap_left = pick_wait(in_quiet);
                    if ($urandom_range(0, 149) == 0)
                    begin
                        in_quiet = !in_quiet;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result side at random and check each result taken
    int  stall_left = 0;
    int  stall_roll;
    bit  out_quiet = 1'b0;
    parse_result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (awaited_parses.size() == 0)
                begin
                    report_mismatch($sformatf("result with none expected, value %h", value));
                end
                else
                begin
                    want = awaited_parses.pop_front();
                    if (value !== want.value)
                    begin
                        report_mismatch($sformatf("value %h, expected %h", value, want.value));
                    end
                    if (end_offset !== want.end_offset)
                    begin
                        report_mismatch($sformatf("end_offset %0d, expected %0d",
                                                  end_offset, want.end_offset));
                    end
                    if (found_digits !== want.found)
                    begin
                        report_mismatch($sformatf("found_digits %b, expected %b",
                                                  found_digits, want.found));
                    end
                    if (overflow !== want.wrap)
                    begin
                        report_mismatch($sformatf("overflow %b, expected %b",
                                                  overflow, want.wrap));
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_roll = pick_wait(out_quiet);
                out_stall <= (stall_roll != 0);
                if (stall_roll != 0)
                begin
                    stall_left = stall_roll - 1;
                end
            end
            if ($urandom_range(0, 149) == 0)
            begin
                out_quiet = !out_quiet;
            end
        end
    end

    // Count cycles in which neither side moves an item
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= IdleLimit);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        // Character while idle with no opening mark: dropped
        gen_opening = 1'b0;
        put_char(CharUpZ);
        // Blank skip and minus in signed mode
        begin_string(BaseDec, 1'b1);
        put_text("\t-7");
        put_char(CharNul);
        // Minus in unsigned mode stops at once
        begin_string(BaseDec, 1'b0);
        put_text("-5");
        // Auto base with 0x prefix
        begin_string(BaseAuto, 1'b1);
        put_text("0x1F");
        put_char(CharNul);
        // Auto base with leading zero picks octal
        begin_string(BaseAuto, 1'b0);
        put_text("078");
        // Hex base with 0x and no hex digit after it
        begin_string(BaseHex, 1'b0);
        put_text("0xg");
        // Blank after a sign is not skipped
        begin_string(BaseDec, 1'b1);
        put_text("+ 1");
        // New string opened mid-string drops the old one
        begin_string(BaseDec, 1'b0);
        put_text("12");
        begin_string(BaseMax, 1'b1);
        put_text("z!");
        // Base one accepts only zero
        begin_string(BaseUnary, 1'b0);
        put_text("01");
        // Base beyond 36 accepts every letter
        begin_string(BaseTop, 1'b1);
        put_text("Zz");
        put_char(8'hff);

        // Blank run, then a bare 0x
        begin_string(BaseAuto, 1'b0);
        repeat (5) put_char(random_blank());
        put_text("0xz");

        random_count = 0;
        while (random_count < RandomItems)
        begin
            gen_random_string();
        end
        total_items = pending_items.size() + accepted_count;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count != total_items || pending_items.size() != 0)
        begin
            @(negedge clk);
        end
        while (awaited_parses.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DrainCycles) @(negedge clk);

        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/sip_pkg.sv
rtl/sip_mac.sv
rtl/sip_core.sv
rtl/string_to_integer_parser.sv
test/tb_string_to_integer_parser.sv
